// File: rtl/tclm_pkg.sv
package tclm_pkg;

  localparam int NCHAN      = 3;
  localparam int DEPTH      = 256;
  localparam int DEPTH_W    = $clog2(DEPTH);
  localparam int CH_W       = 2;
  localparam int ADDR_W     = CH_W + DEPTH_W;
  localparam int CNT_W      = 16;
  localparam int POS_W      = 4;
  localparam int MARKER_LEN = 10;
  localparam int TAG_POS    = 6;
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);
  localparam int CFG_IDX_W  = 2;

  localparam logic [CH_W-1:0] CH_COM  = 2'd0;
  localparam logic [CH_W-1:0] CH_SNF  = 2'd1;
  localparam logic [CH_W-1:0] CH_DBG  = 2'd2;
  localparam logic [CH_W-1:0] CH_NONE = 2'd3;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_COM_TAG = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SNF_TAG = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DBG_TAG = 2'd2;

  localparam logic [7:0] COM_TAG_RST = 8'd49;
  localparam logic [7:0] SNF_TAG_RST = 8'd50;
  localparam logic [7:0] DBG_TAG_RST = 8'd48;

  typedef struct packed {
    logic            is_tick;
    logic [CH_W-1:0] chan;
    logic [7:0]      data;
  } cmd_t;

  // marker: newline "<gLog" tag ">:" newline
  function automatic logic [7:0] marker_byte(input logic [POS_W-1:0] pos,
                                             input logic [7:0] tag);
    logic [7:0] b;
    unique case (pos)
      4'd1:    b = 8'h3C;
      4'd2:    b = 8'h67;
      4'd3:    b = 8'h4C;
      4'd4:    b = 8'h6F;
      4'd5:    b = 8'h67;
      4'd6:    b = tag;
      4'd7:    b = 8'h3E;
      4'd8:    b = 8'h3A;
      default: b = 8'h0A;
    endcase
    return b;
  endfunction

  function automatic logic [CH_W-1:0] pref_first(input logic [CH_W-1:0] ch);
    return (ch == CH_COM) ? CH_SNF : CH_COM;
  endfunction

  function automatic logic [CH_W-1:0] pref_second(input logic [CH_W-1:0] ch);
    return (ch == CH_DBG) ? CH_SNF : CH_DBG;
  endfunction

endpackage

// File: rtl/tclm_front.sv
module tclm_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,  // data_byte
  input  logic [2:0]           s_axis_tuser,  // op, channel[1:0]
  output logic                 cmd_valid,
  input  logic                 cmd_ready,
  output tclm_pkg::cmd_t       cmd
);
  import tclm_pkg::*;

  cmd_t               q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic               push;
  logic               pop;
  cmd_t               in_cmd;

  assign s_axis_tready = (count != Q_CNT_W'(Q_DEPTH));
  assign in_cmd.is_tick = s_axis_tuser[0];
  assign in_cmd.chan    = s_axis_tuser[2:1];
  assign in_cmd.data    = s_axis_tdata;

  // puts to the unused channel code are dropped here
  assign push = s_axis_tvalid && s_axis_tready &&
                ((in_cmd.is_tick == OP_TICK) || (in_cmd.chan != CH_NONE));
  assign cmd_valid = (count != '0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= in_cmd;
    end
  end

endmodule

// File: rtl/tclm_back.sv
module tclm_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cmd_valid,
  output logic                               cmd_ready,
  input  tclm_pkg::cmd_t                     cmd,
  input  logic                               cfg_valid,
  input  logic [tclm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [7:0]                         cfg_data,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [7:0]                         m_axis_tdata,
  output logic [tclm_pkg::CH_W-1:0]          m_axis_tuser
);
  import tclm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t           state;
  logic [7:0]       mem [NCHAN*DEPTH];
  logic [7:0]       rd_data;
  logic [CNT_W-1:0] rd_cnt [NCHAN];
  logic [CNT_W-1:0] wr_cnt [NCHAN];
  logic [7:0]       tag [NCHAN];
  logic [CH_W-1:0]  cur;
  logic [POS_W-1:0] mpos;
  logic [NCHAN-1:0] has_data;
  logic             take;
  logic             put;
  logic             tick;
  logic             send_mark;
  logic             out_free;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [CH_W-1:0]  pf;
  logic [CH_W-1:0]  ps;

  always_comb begin
    for (int i = 0; i < NCHAN; i++) begin
      has_data[i] = (rd_cnt[i] != wr_cnt[i]);
    end
  end

  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign cmd_ready = (state == S_IDLE) && (!cmd.is_tick || out_free);
  assign take      = cmd_valid && cmd_ready;
  assign put       = take && (cmd.is_tick == OP_PUT);
  assign tick      = take && (cmd.is_tick == OP_TICK);
  assign send_mark = tick && (mpos < POS_W'(MARKER_LEN));
  assign wr_addr   = {cmd.chan, wr_cnt[cmd.chan][DEPTH_W-1:0]};
  assign rd_addr   = {cur, rd_cnt[cur][DEPTH_W-1:0]};
  assign pf        = pref_first(cur);
  assign ps        = pref_second(cur);

  always_ff @(posedge clk) begin
    if (put) begin
      mem[wr_addr] <= cmd.data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      cur           <= CH_DBG;
      mpos          <= '0;
      m_axis_tvalid <= 1'b0;
      tag[0]        <= COM_TAG_RST;
      tag[1]        <= SNF_TAG_RST;
      tag[2]        <= DBG_TAG_RST;
      for (int i = 0; i < NCHAN; i++) begin
        rd_cnt[i] <= '0;
        wr_cnt[i] <= '0;
      end
    end else begin
      if (send_mark || (state == S_READ)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_COM_TAG: tag[0] <= cfg_data;
          REG_SNF_TAG: tag[1] <= cfg_data;
          REG_DBG_TAG: tag[2] <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (put) begin
            wr_cnt[cmd.chan] <= wr_cnt[cmd.chan] + 1'b1;
          end
          if (tick) begin
            if (mpos < POS_W'(MARKER_LEN)) begin
              m_axis_tdata  <= marker_byte(mpos, tag[cur]);
              m_axis_tuser  <= cur;
              mpos          <= mpos + 1'b1;
            end else if (has_data[cur]) begin
              state <= S_READ;
            end else if (has_data[pf]) begin
              cur  <= pf;
              mpos <= '0;
            end else if (has_data[ps]) begin
              cur  <= ps;
              mpos <= '0;
            end
          end
        end
        S_READ: begin
          m_axis_tdata  <= rd_data;
          m_axis_tuser  <= cur;
          rd_cnt[cur]   <= rd_cnt[cur] + 1'b1;
          state         <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/three_channel_tagged_log_mux.sv
// A tick that sends a marker byte passes the front-end queue and the output register;
// a tick that sends a ring byte also passes S_READ and the registered memory read.
// Throughput: one put per cycle while the back end is in S_IDLE; a ring-byte tick
// holds the back end in S_READ, and every tick waits for the output register to free.
// Reset (rst, synchronous): counts cleared, current channel DBG, marker restarted,
// tags reloaded; the ring memory is not cleared.
module three_channel_tagged_log_mux (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // data_byte
  input  logic [2:0]                      s_axis_tuser,  // op, channel[1:0]
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [7:0]                      m_axis_tdata,  // tx_byte
  output logic [1:0]                      m_axis_tuser,  // tx_channel[1:0]
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tclm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                      cfg_data
);
  import tclm_pkg::*;

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  assign cfg_ready = 1'b1;

  tclm_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .cmd           (cmd)
  );

  tclm_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .cmd           (cmd),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// File: rtl/tclm_checker.sv
module tclm_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [1:0] m_axis_tuser
);

  a_no_out_in_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output transaction offered right after reset");

  a_ready_after_reset: assert property (@(posedge clk) $past(rst) |-> s_axis_tready)
    else $error("input not ready after reset");

  a_valid_channel: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser != 2'd3))
    else $error("transaction on unused channel code");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled output transaction changed");

endmodule

bind three_channel_tagged_log_mux tclm_checker u_tclm_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// File: verif/log_mux_checker.sv
`timescale 1ns / 100ps
module log_mux_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,   // data_byte
  input  logic [2:0]                     s_axis_tuser,   // op, channel[1:0]
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [7:0]                     m_axis_tdata,   // tx_byte
  input  logic [1:0]                     m_axis_tuser,   // tx_channel[1:0]
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [tclm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data,
  output int                             mismatches,
  output int                             tx_pending
);
  import tclm_pkg::*;

  typedef struct packed {
    logic [7:0]      tx_byte;
    logic [CH_W-1:0] chan;
  } tx_t;

  // index 0 is sent first; the tag slot is filled from the tag register
  localparam logic [MARKER_LEN-1:0][7:0] MARKER_TEXT = {
    8'h0A, 8'h3A, 8'h3E, 8'h00, 8'h67, 8'h6F, 8'h4C, 8'h67, 8'h3C, 8'h0A
  };

  logic [7:0]       tag_q  [NCHAN];
  logic [7:0]       ring   [NCHAN][DEPTH];
  logic [CNT_W-1:0] rd_cnt [NCHAN];
  logic [CNT_W-1:0] wr_cnt [NCHAN];
  logic [CH_W-1:0]  cur_ch;
  logic [POS_W-1:0] marker_pos;
  tx_t              pending_tx [$];
  int               err_cnt = 0;

  function automatic logic has_bytes(input logic [CH_W-1:0] ch);
    return rd_cnt[ch] != wr_cnt[ch];
  endfunction

  task automatic apply_log_item(input logic op, input logic [CH_W-1:0] ch,
                                input logic [7:0] d);
    logic [CH_W-1:0] alt1;
    logic [CH_W-1:0] alt2;
    tx_t t;
    if (op == OP_PUT) begin
      if (ch != CH_NONE) begin
        ring[ch][wr_cnt[ch][DEPTH_W-1:0]] = d;
        wr_cnt[ch] = wr_cnt[ch] + 1'b1;
      end
    end else if (marker_pos < MARKER_LEN) begin
      t.tx_byte = (marker_pos == TAG_POS) ? tag_q[cur_ch] : MARKER_TEXT[marker_pos];
      t.chan = cur_ch;
      pending_tx.push_back(t);
      marker_pos = marker_pos + 1'b1;
    end else if (has_bytes(cur_ch)) begin
      t.tx_byte = ring[cur_ch][rd_cnt[cur_ch][DEPTH_W-1:0]];
      t.chan = cur_ch;
      pending_tx.push_back(t);
      rd_cnt[cur_ch] = rd_cnt[cur_ch] + 1'b1;
    end else begin
      case (cur_ch)
        CH_COM: begin
          alt1 = CH_SNF;
          alt2 = CH_DBG;
        end
        CH_SNF: begin
          alt1 = CH_COM;
          alt2 = CH_DBG;
        end
        default: begin
          alt1 = CH_COM;
          alt2 = CH_SNF;
        end
      endcase
      if (has_bytes(alt1)) begin
        cur_ch = alt1;
        marker_pos = '0;
      end else if (has_bytes(alt2)) begin
        cur_ch = alt2;
        marker_pos = '0;
      end
    end
  endtask

  always @(posedge clk) begin
    tx_t got;
    tx_t want;
    if (rst) begin
      tag_q[CH_COM] = COM_TAG_RST;
      tag_q[CH_SNF] = SNF_TAG_RST;
      tag_q[CH_DBG] = DBG_TAG_RST;
      for (int c = 0; c < NCHAN; c++) begin
        rd_cnt[c] = '0;
        wr_cnt[c] = '0;
      end
      cur_ch = CH_DBG;
      marker_pos = '0;
      pending_tx.delete();
    end else begin
      if (cfg_valid && cfg_ready && cfg_index < NCHAN)
        tag_q[cfg_index] = cfg_data;
      if (s_axis_tvalid && s_axis_tready)
        apply_log_item(s_axis_tuser[0], s_axis_tuser[2:1], s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        got.tx_byte = m_axis_tdata;
        got.chan = m_axis_tuser;
        if (pending_tx.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("%0t: unexpected transaction tx_byte=%02h tx_channel=%0d",
                     $realtime, got.tx_byte, got.chan);
        end else begin
          want = pending_tx.pop_front();
          if (got.tx_byte !== want.tx_byte || got.chan !== want.chan) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("%0t: mismatch tx_byte exp %02h got %02h, tx_channel exp %0d got %0d",
                       $realtime, want.tx_byte, got.tx_byte, want.chan, got.chan);
          end
        end
      end
    end
    mismatches <= err_cnt;
    tx_pending <= pending_tx.size();
  end

endmodule

// File: verif/three_channel_tagged_log_mux_tb.sv
`timescale 1ns / 100ps
module three_channel_tagged_log_mux_tb;
  import tclm_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int ITEMS_PER_PHASE = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata = '0;   // data_byte
  logic [2:0]           s_axis_tuser = '0;   // op, channel[1:0]
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [7:0]           m_axis_tdata;        // tx_byte
  logic [1:0]           m_axis_tuser;        // tx_channel[1:0]
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = '0;
  int                   mismatches;
  int                   tx_pending;

  int cycles = 0;
  int stall_left = 0;
  int steady_left = 0;
  bit steady_send = 1'b0;

  three_channel_tagged_log_mux uut (.*);
  log_mux_checker tx_check (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[three_channel_tagged_log_mux] ERROR");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if (steady_left > 0)
        steady_left <= steady_left - 1;
      else if ($urandom_range(0, 49) == 0)
        steady_left <= $urandom_range(50, 200);
      else if ($urandom_range(0, 2) == 0)
        stall_left <= gap_len();
    end
  end

  task automatic send_item(input logic op, input logic [CH_W-1:0] ch, input logic [7:0] d);
    int gap;
    gap = steady_send ? 0 : gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= {ch, op};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // hold the sender until every expected transaction is out
  task automatic settle(input int extra);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (tx_pending != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_tag(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random(input int n);
    int tick_pct;
    tick_pct = 50;
    for (int i = 0; i < n; i++) begin
      if (i % 50 == 0) begin
        case ($urandom_range(0, 2))
          0:       tick_pct = 20;
          1:       tick_pct = 50;
          default: tick_pct = 80;
        endcase
        steady_send = ($urandom_range(0, 4) == 0);
      end
      if (i == n / 2)
        settle(0);
      if ($urandom_range(0, 99) < tick_pct)
        send_item(OP_TICK, CH_W'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      else if ($urandom_range(0, 19) == 0)
        send_item(OP_PUT, CH_NONE, 8'($urandom_range(0, 255)));
      else
        send_item(OP_PUT, CH_W'($urandom_range(0, 2)), 8'($urandom_range(0, 255)));
    end
    steady_send = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // DBG marker with all channels empty, then a tick that finds nothing
    repeat (11) send_item(OP_TICK, CH_NONE, 8'hFF);
    send_item(OP_PUT, CH_COM, 8'h00);
    send_item(OP_PUT, CH_COM, 8'hFF);
    send_item(OP_PUT, CH_NONE, 8'h77);
    send_item(OP_PUT, CH_DBG, 8'hA5);
    // DBG byte, switch to COM, COM marker, two bytes, all empty again
    repeat (15) send_item(OP_TICK, CH_COM, 8'h00);

    // SNF writer runs more than a full ring ahead of the reader
    settle(SETTLE_CYCLES);
    steady_send = 1'b1;
    repeat (DEPTH + 44) send_item(OP_PUT, CH_SNF, 8'($urandom_range(0, 255)));
    send_item(OP_TICK, CH_DBG, 8'h5A);
    steady_send = 1'b0;

    settle(SETTLE_CYCLES);
    write_tag(REG_COM_TAG, 8'h00);
    write_tag(REG_SNF_TAG, 8'hFF);
    write_tag(REG_DBG_TAG, 8'h80);
    write_tag(REG_UNUSED, 8'hFF);
    run_random(ITEMS_PER_PHASE);

    settle(SETTLE_CYCLES);
    write_tag(REG_COM_TAG, 8'hFF);
    write_tag(REG_SNF_TAG, 8'h00);
    write_tag(REG_DBG_TAG, 8'h7F);
    run_random(ITEMS_PER_PHASE);

    // identical tags on all channels
    settle(SETTLE_CYCLES);
    write_tag(REG_COM_TAG, 8'h41);
    write_tag(REG_SNF_TAG, 8'h41);
    write_tag(REG_DBG_TAG, 8'h41);
    write_tag(REG_UNUSED, 8'h00);
    run_random(ITEMS_PER_PHASE);

    settle(SETTLE_CYCLES);
    write_tag(REG_COM_TAG, 8'($urandom_range(0, 255)));
    write_tag(REG_SNF_TAG, 8'($urandom_range(0, 255)));
    write_tag(REG_DBG_TAG, 8'($urandom_range(0, 255)));
    run_random(ITEMS_PER_PHASE);

    settle(20);
    if (mismatches == 0 && tx_pending == 0)
      $display("[three_channel_tagged_log_mux] OK");
    else
      $display("[three_channel_tagged_log_mux] ERROR");
    $finish;
  end

endmodule
